### rtl/waveform_oscillator_mixer_top_macros.svh
// assertion helpers for the oscillator mixer
`ifndef WAVEFORM_OSCILLATOR_MIXER_TOP_MACROS_SVH
`define WAVEFORM_OSCILLATOR_MIXER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WOM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// next-cycle implication
`define WOM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define WOM_ASSERT_IMPL(lbl, ante, cons)
`define WOM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/wom_pkg.sv
`default_nettype none
package wom_pkg;

	// field and datapath widths
	localparam int PHASE_W    = 32;
	localparam int STEP_W     = 31;
	localparam int AMP_W      = 16;
	localparam int MIX_W      = 16;
	localparam int LEVEL_W    = 17;
	localparam int PROD_W     = LEVEL_W + AMP_W;
	localparam int SCALE_W    = PROD_W + 17;
	localparam int VOICE_W    = SCALE_W - 32;
	localparam int SUM_W      = VOICE_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// sine table geometry: quarter wave stored, rest by symmetry
	localparam int SINE_DEPTH = 1024;
	localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
	localparam int QTR_W      = SINE_IDX_W - 2;
	localparam int QTR_DEPTH  = 1 << QTR_W;

	// level constants, 65536 is unity
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(65536);
	localparam logic [LEVEL_W-1:0] LEVEL_HALF = LEVEL_W'(32768);

	// full scale per sample depth
	localparam logic [MIX_W-1:0] FS_WIDE   = MIX_W'(65535);
	localparam logic [MIX_W-1:0] FS_NARROW = MIX_W'(255);

	// rounding bias ahead of the final 32-bit shift
	localparam logic [SCALE_W-1:0] ROUND_BIAS = SCALE_W'(64'h8000_0000);

	// fixed-point constants for building the sine table
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'h4000_0000;

	typedef enum logic [1:0] {
		WAVE_SINE   = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_SAW    = 2'd2,
		WAVE_TRI    = 2'd3
	} wave_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVEFORM     = 2'd0,
		REG_PHASE_STEP   = 2'd1,
		REG_AMPLITUDE    = 2'd2,
		REG_SAMPLE_DEPTH = 2'd3
	} cfg_reg_t;

	// register file contents seen by the datapath
	typedef struct packed {
		wave_t                waveform;
		logic [STEP_W-1:0]    phase_step;
		logic [AMP_W-1:0]     amplitude;
		logic                 sample_depth;
	} cfg_t;

	// table entry: {half-step tie flag, level of the upper half wave}
	typedef logic [LEVEL_W:0] sine_ent_t;
	typedef logic [QTR_DEPTH-1:0][LEVEL_W:0] sine_tab_t;

	// one quarter-wave entry, Q30 Taylor series, evaluated at elaboration
	function automatic sine_ent_t sine_entry(input int unsigned m);
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		logic        tie;
		r    = 64'(m) << (30 - QTR_W);
		x    = (r * HALF_PI_Q30) >> 30;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		if (sum > Q30_ONE) begin
			sum = Q30_ONE;
		end
		v   = (((Q30_ONE + sum) << 16) + Q30_ONE) >> 31;
		// lower half wave rounds up one more when the fraction is exactly one half
		tie = (sum[14:0] == 15'h4000);
		return {tie, v[LEVEL_W-1:0]};
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		int        i;
		for (i = 0; i < QTR_DEPTH; i++) begin
			t[i] = sine_entry(i);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB  = build_sine_tab();
	localparam sine_ent_t SINE_PEAK = sine_entry(QTR_DEPTH);

endpackage
`default_nettype wire

### rtl/mix_in_if.sv
`default_nettype none
interface mix_in_if import wom_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MIX_W-1:0] mix_in;

	modport source (output valid, output mix_in, input ready);
	modport sink (input valid, input mix_in, output ready);
endinterface
`default_nettype wire

### rtl/mix_out_if.sv
`default_nettype none
interface mix_out_if import wom_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MIX_W-1:0] mix_out;
	logic             clipped;

	modport source (output valid, output mix_out, output clipped, input ready);
	modport sink (input valid, input mix_out, input clipped, output ready);
endinterface
`default_nettype wire

### rtl/cfg_if.sv
`default_nettype none
interface cfg_if import wom_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/waveform_oscillator_mixer_top.sv
`default_nettype none
`include "waveform_oscillator_mixer_top_macros.svh"
// Oscillator voice mixer: each word on din is one audio frame's running mix
// sample; the block adds one sine, square, saw or triangle voice from a
// 32-bit phase accumulator, scaled by the Q0.16 amplitude and the full scale
// of the sample depth, rounds half up and clamps at 255 or 65535 (clipped
// flags a clamp). One word is taken every cycle; a result reaches dout
// through input, product, voice and output registers, and the pipeline
// only stalls when dout is held off with all four full. The phase
// accumulator moves once per accepted word, so the figure of one word per
// cycle is set by that phase and level update.
// Configuration writes are taken at any time on cfg but must only be made
// while no frame is in flight.
module waveform_oscillator_mixer_top import wom_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	cfg_if.sink       cfg,
	mix_in_if.sink    din,
	mix_out_if.source dout
);

	cfg_t               cfg_q;
	logic               take;
	logic [LEVEL_W-1:0] level;
	logic [MIX_W-1:0]   fs_now;
	logic               square_lvl;
	logic               hold_phase;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.waveform     <= WAVE_SINE;
			cfg_q.phase_step   <= '0;
			cfg_q.amplitude    <= AMP_W'(52429);
			cfg_q.sample_depth <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_WAVEFORM: begin
					cfg_q.waveform <= wave_t'(cfg.data[1:0]);
				end
				REG_PHASE_STEP: begin
					cfg_q.phase_step <= cfg.data[STEP_W-1:0];
				end
				REG_AMPLITUDE: begin
					cfg_q.amplitude <= cfg.data[AMP_W-1:0];
				end
				REG_SAMPLE_DEPTH: begin
					cfg_q.sample_depth <= cfg.data[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	wom_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.cfg    (cfg_q),
		.level  (level)
	);

	wom_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg_q),
		.level  (level),
		.take   (take)
	);

	// terms for the checks
	assign fs_now     = cfg_q.sample_depth ? FS_WIDE : FS_NARROW;
	assign square_lvl = (level == LEVEL_HALF) || (level == LEVEL_FULL);
	assign hold_phase = take && (cfg_q.waveform != WAVE_TRI) && (cfg_q.phase_step == '0);

	// checks
	`WOM_ASSERT_IMPL(a_clip_at_fs, dout.valid && dout.clipped, dout.mix_out == fs_now)
	`WOM_ASSERT_IMPL(a_narrow_in_range, dout.valid && !cfg_q.sample_depth, dout.mix_out <= fs_now)
	`WOM_ASSERT_IMPL(a_stall_only_full, !din.ready, dout.valid && !dout.ready)
	`WOM_ASSERT_IMPL(a_square_levels, cfg_q.waveform == WAVE_SQUARE, square_lvl)
	`WOM_ASSERT_NEXT(a_zero_step_holds, hold_phase, $stable(level))

endmodule
`default_nettype wire

### rtl/wom_phase.sv
`default_nettype none
module wom_phase import wom_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire cfg_t               cfg,
	output logic [LEVEL_W-1:0]      level
);

	localparam int TW = PHASE_W + 2;
	localparam logic signed [TW-1:0] TRI_MAX = TW'((64'd1 << (PHASE_W - 1)) - 64'd1);
	localparam logic signed [TW-1:0] TRI_MIN = -TRI_MAX;
	localparam logic [PHASE_W-1:0]   HALF_PHASE = PHASE_W'(64'd1 << (PHASE_W - 1));

	logic [PHASE_W-1:0]    phase_q;
	logic                  falling_q;

	logic [SINE_IDX_W-1:0] sine_idx;
	logic [1:0]            quad;
	logic [QTR_W-1:0]      qtr_pos;
	logic [QTR_W-1:0]      qtr_idx;
	logic                  at_peak;
	sine_ent_t             ent;
	logic [LEVEL_W-1:0]    sine_lvl;

	logic signed [TW-1:0]  s_tri;
	logic signed [TW-1:0]  d_tri;
	logic signed [TW-1:0]  fwd;
	logic signed [TW-1:0]  rev;
	logic signed [TW-1:0]  nx;
	logic                  bounce;
	logic [PHASE_W-1:0]    tri_next;
	logic [PHASE_W-1:0]    wrap_next;

	// sine lookup: quarter table mirrored in phase, lower half mirrored in level
	always_comb begin
		sine_idx = phase_q[PHASE_W-1 -: SINE_IDX_W];
		quad     = sine_idx[SINE_IDX_W-1 -: 2];
		qtr_pos  = sine_idx[QTR_W-1:0];
		qtr_idx  = quad[0] ? (QTR_W'(0) - qtr_pos) : qtr_pos;
		at_peak  = quad[0] && (qtr_pos == '0);
		ent      = at_peak ? SINE_PEAK : SINE_TAB[qtr_idx];
		if (quad[1]) begin
			sine_lvl = LEVEL_FULL - ent[LEVEL_W-1:0] + LEVEL_W'(ent[LEVEL_W]);
		end else begin
			sine_lvl = ent[LEVEL_W-1:0];
		end
	end

	// level of the current phase for each waveform
	always_comb begin
		case (cfg.waveform)
			WAVE_SINE: begin
				level = sine_lvl;
			end
			WAVE_SQUARE: begin
				level = (phase_q > HALF_PHASE) ? LEVEL_FULL : LEVEL_HALF;
			end
			WAVE_SAW: begin
				level = {1'b0, phase_q[PHASE_W-1 -: 16]};
			end
			WAVE_TRI: begin
				level = {1'b0, ~phase_q[PHASE_W-1], phase_q[PHASE_W-2 -: 15]};
			end
			default: begin
				level = sine_lvl;
			end
		endcase
	end

	// triangle walk: bounce off +-pi, then clamp inside the open range
	always_comb begin
		s_tri  = TW'($signed(phase_q));
		d_tri  = falling_q ? -$signed(TW'(cfg.phase_step)) : $signed(TW'(cfg.phase_step));
		fwd    = s_tri + d_tri;
		rev    = s_tri - d_tri;
		bounce = (fwd < TRI_MIN) || (fwd > TRI_MAX);
		nx     = bounce ? rev : fwd;
		if (nx < TRI_MIN) begin
			nx = TRI_MIN;
		end else if (nx > TRI_MAX) begin
			nx = TRI_MAX;
		end
		tri_next  = nx[PHASE_W-1:0];
		wrap_next = phase_q + PHASE_W'(cfg.phase_step);
	end

	// accumulator advances once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			falling_q <= 1'b0;
		end else if (take) begin
			if (cfg.waveform == WAVE_TRI) begin
				phase_q   <= tri_next;
				falling_q <= falling_q ^ bounce;
			end else begin
				phase_q   <= wrap_next;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/wom_mix.sv
`default_nettype none
module wom_mix import wom_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	mix_in_if.sink                  din,
	mix_out_if.source               dout,
	input  wire cfg_t               cfg,
	input  wire logic [LEVEL_W-1:0] level,
	output logic                    take
);

	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;
	logic                 out_v_q;
	logic [LEVEL_W-1:0]   level_s1;
	logic [MIX_W-1:0]     mix_s1;
	logic [PROD_W-1:0]    prod_s2;
	logic [MIX_W-1:0]     mix_s2;
	logic [VOICE_W-1:0]   voice_s3;
	logic [MIX_W-1:0]     mix_s3;
	logic [MIX_W-1:0]     mix_out_q;
	logic                 clipped_q;

	logic                 en_s2;
	logic                 en_s3;
	logic                 en_out;
	logic [SCALE_W-1:0]   prod_ext;
	logic [SCALE_W-1:0]   scaled;
	logic [SCALE_W-1:0]   rounded;
	logic [SUM_W-1:0]     sum;
	logic [MIX_W-1:0]     full_scale;
	logic                 over;

	// stall chain: a stage moves when the next one is empty or moving
	assign en_out    = !out_v_q || dout.ready;
	assign en_s3     = !v_s3 || en_out;
	assign en_s2     = !v_s2 || en_s3;
	assign din.ready = !v_s1 || en_s2;
	assign take      = din.valid && din.ready;

	// full-scale multiply as shift and subtract, then round half up
	always_comb begin
		prod_ext = SCALE_W'(prod_s2);
		if (cfg.sample_depth) begin
			scaled = (prod_ext << 16) - prod_ext;
		end else begin
			scaled = (prod_ext << 8) - prod_ext;
		end
		rounded = scaled + ROUND_BIAS;
	end

	// saturating add into the running mix
	always_comb begin
		full_scale = cfg.sample_depth ? FS_WIDE : FS_NARROW;
		sum        = SUM_W'(mix_s3) + SUM_W'(voice_s3);
		over       = sum > SUM_W'(full_scale);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (din.ready) begin
				v_s1 <= din.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_v_q <= v_s3;
			end
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		if (take) begin
			level_s1 <= level;
			mix_s1   <= din.mix_in;
		end
		if (en_s2) begin
			prod_s2 <= PROD_W'(level_s1) * PROD_W'(cfg.amplitude);
			mix_s2  <= mix_s1;
		end
		if (en_s3) begin
			voice_s3 <= rounded[SCALE_W-1 -: VOICE_W];
			mix_s3   <= mix_s2;
		end
		if (en_out) begin
			mix_out_q <= over ? full_scale : sum[MIX_W-1:0];
			clipped_q <= over;
		end
	end

	assign dout.valid   = out_v_q;
	assign dout.mix_out = mix_out_q;
	assign dout.clipped = clipped_q;

endmodule
`default_nettype wire
